### src/free_slot_allocator_top_defines.svh
// assertion macros for the slot allocator top level
`ifndef FREE_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define FREE_SLOT_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define FSA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define FSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/fsa_pkg.sv
// shared types and constants of the slot allocator
`timescale 1ns / 1ps

package fsa_pkg;

	localparam int WORD_W         = 32;
	localparam int BIT_W          = $clog2(WORD_W);
	localparam int SLOT_W         = 10;
	localparam int CFG_W          = 11;
	localparam int POOL_SLOTS_DEF = 1024;
	localparam int CFG_RESET      = 1024;

	typedef enum logic {
		REQ_ALLOC   = 1'b0,
		REQ_RELEASE = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_FREE  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_ALLOC_EVAL,
		S_REL_EVAL,
		S_FINISH
	} fsa_state_t;

	typedef struct packed {
		req_t              req_type;
		logic [SLOT_W-1:0] slot_index;
	} req_item_t;

	typedef struct packed {
		logic [SLOT_W-1:0] granted_slot;
		status_t           status;
	} rsp_item_t;

	// window of one row visit of the scan
	typedef struct packed {
		logic             first;
		logic             fin;
		logic [BIT_W-1:0] off;
		logic [BIT_W:0]   lim;
	} scan_win_t;

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] pos;
	} find_res_t;

endpackage

### src/fsa_find_unit.sv
// find-first-free unit over one bitmap row
`timescale 1ns / 1ps

module fsa_find_unit (
	input  logic [fsa_pkg::WORD_W-1:0] data,
	input  fsa_pkg::scan_win_t         win,
	output fsa_pkg::find_res_t         res
);

	logic [fsa_pkg::WORD_W-1:0] cand;
	logic [fsa_pkg::WORD_W-1:0] iso;
	logic [fsa_pkg::BIT_W-1:0]  pos_v;
	logic [fsa_pkg::BIT_W:0]    ib;
	logic [fsa_pkg::BIT_W:0]    off_x;
	logic                       in_win;

	// candidate bits: free, below the row limit, inside the circular window
	always_comb begin
		off_x = {1'b0, win.off};
		for (int i = 0; i < fsa_pkg::WORD_W; i++) begin
			ib = (fsa_pkg::BIT_W+1)'(i);
			if (win.first) begin
				in_win = (ib >= off_x);
			end else if (win.fin) begin
				in_win = (ib < off_x);
			end else begin
				in_win = 1'b1;
			end
			cand[i] = !data[i] && (ib < win.lim) && in_win;
		end
	end

	// isolate lowest candidate, then encode it
	always_comb begin
		iso   = cand & (~cand + fsa_pkg::WORD_W'(1));
		pos_v = '0;
		for (int i = 0; i < fsa_pkg::WORD_W; i++) begin
			if (iso[i]) begin
				pos_v = pos_v | fsa_pkg::BIT_W'(i);
			end
		end
		res.found = |cand;
		res.pos   = pos_v;
	end

endmodule

### src/free_slot_allocator_top.sv
// next-fit slot allocator: bitmap row memory, scan sequencer and result register
// release: row read, bit check, result; an out-of-range index goes straight to the result
// allocate: row read and row check for every bitmap row the scan visits until a slot is granted,
//   then the held granted row and any further rows are checked for the next free slot
// result load waits while the result stall holds a word; next request taken back in idle
// arst_n clears control, row valid bits (all slots read free), pointer; count to reset value
`timescale 1ns / 1ps
`include "free_slot_allocator_top_defines.svh"

module free_slot_allocator_top #(
	parameter int POOL_SLOTS = fsa_pkg::POOL_SLOTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// request channel
	input  logic                      req_valid,
	output logic                      req_stall,
	input  fsa_pkg::req_item_t        req,
	// result channel
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output fsa_pkg::rsp_item_t        rsp,
	// slot count register write
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [fsa_pkg::CFG_W-1:0] cfg_data
);

	// bitmap geometry: rows of one word each
	localparam int ROWS    = (POOL_SLOTS + fsa_pkg::WORD_W - 1) / fsa_pkg::WORD_W;
	localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int POS_W   = ROW_W + fsa_pkg::BIT_W;
	localparam int CNT_W   = POS_W + 1;
	localparam int CNT_RST = (fsa_pkg::CFG_RESET > POOL_SLOTS) ?
		POOL_SLOTS : fsa_pkg::CFG_RESET;

	localparam int WW = fsa_pkg::WORD_W;
	localparam int BW = fsa_pkg::BIT_W;

	fsa_pkg::fsa_state_t state_q, state_d;

	// sequencer registers
	fsa_pkg::req_t       req_q;
	fsa_pkg::status_t    status_q;
	logic [ROW_W-1:0]    cur_row_q;
	logic [ROW_W-1:0]    start_row_q;
	logic [BW-1:0]       off_q;
	logic                first_q;
	logic                wrapped_q;
	logic                use_held_q;
	logic                phase_q;     // low: finding the grant, high: finding the next pointer
	logic [POS_W-1:0]    grant_q;
	logic [POS_W-1:0]    next_free_q;
	logic [WW-1:0]       word_q;      // granted row, kept for the pointer search
	logic [CNT_W-1:0]    n_q;         // effective slot count

	// result register
	logic                rsp_valid_q;
	fsa_pkg::rsp_item_t  rsp_q;

	// bitmap store: word memory plus one valid bit per row
	logic [WW-1:0]       mem [ROWS];
	logic [WW-1:0]       mem_rdata_q;
	logic                rv_rd_q;
	logic [ROWS-1:0]     row_valid_q;

	// combinational
	logic                req_acc;
	logic                mem_re;
	logic                mem_we;
	logic                load_out;
	logic [WW-1:0]       mem_wdata;
	logic [WW-1:0]       eval_data;
	logic [CNT_W-1:0]    nm1;
	logic [ROW_W-1:0]    last_row;
	logic [BW:0]         last_lim;
	logic [ROW_W-1:0]    row_next;
	logic                at_last_row;
	logic [POS_W-1:0]    start_pos;
	logic [POS_W-1:0]    slot_pos;
	logic [POS_W-1:0]    found_pos;
	logic                slot_oor;
	logic                rel_bit;
	logic [CNT_W-1:0]    cfg_cnt;
	fsa_pkg::scan_win_t  win;
	fsa_pkg::find_res_t  fres;

	assign req_stall = (state_q != fsa_pkg::S_IDLE);
	assign cfg_ready = (state_q == fsa_pkg::S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign req_acc   = req_valid && !req_stall;

	// saturate the written count into 1..POOL_SLOTS
	always_comb begin
		if (cfg_data == '0) begin
			cfg_cnt = CNT_W'(1);
		end else if (32'(cfg_data) > 32'(POOL_SLOTS)) begin
			cfg_cnt = CNT_W'(POOL_SLOTS);
		end else begin
			cfg_cnt = CNT_W'(cfg_data);
		end
	end

	// last managed row and how many of its bits count
	assign nm1         = n_q - CNT_W'(1);
	assign last_row    = nm1[POS_W-1:BW];
	assign last_lim    = {1'b0, nm1[BW-1:0]} + (BW+1)'(1);
	assign at_last_row = (cur_row_q == last_row);
	assign row_next    = at_last_row ? '0 : cur_row_q + ROW_W'(1);

	// search start: pointer, or slot zero once the count has shrunk below it
	assign start_pos = ({1'b0, next_free_q} < n_q) ? next_free_q : '0;
	assign slot_pos  = POS_W'(req.slot_index);
	assign slot_oor  = (32'(req.slot_index) >= 32'(n_q));

	// row under test: held copy after a grant, else memory word (unwritten rows read free)
	assign eval_data = use_held_q ? word_q : (rv_rd_q ? mem_rdata_q : '0);
	assign rel_bit   = eval_data[off_q];

	always_comb begin
		win.first = first_q;
		win.fin   = wrapped_q && (cur_row_q == start_row_q);
		win.off   = off_q;
		win.lim   = at_last_row ? last_lim : (BW+1)'(WW);
	end

	fsa_find_unit u_find (
		.data (eval_data),
		.win  (win),
		.res  (fres)
	);

	assign found_pos = {cur_row_q, fres.pos};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fsa_pkg::S_IDLE: begin
				if (req_acc) begin
					if (req.req_type == fsa_pkg::REQ_RELEASE && slot_oor) begin
						state_d = fsa_pkg::S_FINISH;
					end else begin
						state_d = fsa_pkg::S_READ;
					end
				end
			end
			fsa_pkg::S_READ: begin
				if (req_q == fsa_pkg::REQ_RELEASE) begin
					state_d = fsa_pkg::S_REL_EVAL;
				end else begin
					state_d = fsa_pkg::S_ALLOC_EVAL;
				end
			end
			fsa_pkg::S_REL_EVAL: begin
				state_d = fsa_pkg::S_FINISH;
			end
			fsa_pkg::S_ALLOC_EVAL: begin
				if (!phase_q && fres.found) begin
					state_d = fsa_pkg::S_ALLOC_EVAL;
				end else if (fres.found || win.fin) begin
					state_d = fsa_pkg::S_FINISH;
				end else begin
					state_d = fsa_pkg::S_READ;
				end
			end
			fsa_pkg::S_FINISH: begin
				if (load_out) begin
					state_d = fsa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = fsa_pkg::S_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		load_out  = 1'b0;
		mem_wdata = eval_data;
		case (state_q)
			fsa_pkg::S_READ: begin
				mem_re = 1'b1;
			end
			fsa_pkg::S_REL_EVAL: begin
				mem_we    = rel_bit;
				mem_wdata = eval_data & ~(WW'(1) << off_q);
			end
			fsa_pkg::S_ALLOC_EVAL: begin
				mem_we    = !phase_q && fres.found;
				mem_wdata = eval_data | (WW'(1) << fres.pos);
			end
			fsa_pkg::S_FINISH: begin
				load_out = !rsp_valid_q || !rsp_stall;
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// bitmap word memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cur_row_q] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= mem[cur_row_q];
		end
	end

	// control state: row valid bits, pointer, count, result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rv_rd_q     <= 1'b0;
			next_free_q <= '0;
			n_q         <= CNT_W'(CNT_RST);
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				n_q <= cfg_cnt;
			end
			if (mem_re) begin
				rv_rd_q <= row_valid_q[cur_row_q];
			end
			if (mem_we) begin
				row_valid_q[cur_row_q] <= 1'b1;
			end
			if (state_q == fsa_pkg::S_ALLOC_EVAL && phase_q) begin
				if (fres.found) begin
					next_free_q <= found_pos;
				end else if (win.fin) begin
					// last free slot went out: pointer stays on it
					next_free_q <= grant_q;
				end
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// sequencer payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			fsa_pkg::S_IDLE: begin
				if (req_acc) begin
					req_q      <= req.req_type;
					grant_q    <= '0;
					first_q    <= 1'b1;
					wrapped_q  <= 1'b0;
					use_held_q <= 1'b0;
					phase_q    <= 1'b0;
					status_q   <= fsa_pkg::ST_RANGE;
					if (req.req_type == fsa_pkg::REQ_RELEASE) begin
						cur_row_q   <= slot_pos[POS_W-1:BW];
						start_row_q <= slot_pos[POS_W-1:BW];
						off_q       <= slot_pos[BW-1:0];
					end else begin
						cur_row_q   <= start_pos[POS_W-1:BW];
						start_row_q <= start_pos[POS_W-1:BW];
						off_q       <= start_pos[BW-1:0];
					end
				end
			end
			fsa_pkg::S_REL_EVAL: begin
				status_q <= rel_bit ? fsa_pkg::ST_OK : fsa_pkg::ST_FREE;
			end
			fsa_pkg::S_ALLOC_EVAL: begin
				if (!phase_q && fres.found) begin
					// grant taken: rescan from it with the updated row held
					grant_q     <= found_pos;
					word_q      <= mem_wdata;
					start_row_q <= cur_row_q;
					off_q       <= fres.pos;
					first_q     <= 1'b1;
					wrapped_q   <= 1'b0;
					use_held_q  <= 1'b1;
					phase_q     <= 1'b1;
				end else if (fres.found || win.fin) begin
					status_q <= phase_q ? fsa_pkg::ST_OK : fsa_pkg::ST_FULL;
				end else begin
					cur_row_q  <= row_next;
					wrapped_q  <= wrapped_q || at_last_row;
					first_q    <= 1'b0;
					use_held_q <= 1'b0;
				end
			end
			default: begin
				status_q <= status_q;
			end
		endcase
		if (load_out) begin
			rsp_q.granted_slot <= fsa_pkg::SLOT_W'(grant_q);
			rsp_q.status       <= status_q;
		end
	end

	`FSA_ASSERT_NOW(a_grant_in_range,
		(state_q == fsa_pkg::S_FINISH && req_q == fsa_pkg::REQ_ALLOC
			&& status_q == fsa_pkg::ST_OK),
		({1'b0, grant_q} < n_q && {1'b0, next_free_q} < n_q),
		"granted slot or pointer outside managed slots")
	`FSA_ASSERT_NOW(a_find_free_bit,
		(state_q == fsa_pkg::S_ALLOC_EVAL && fres.found),
		(!eval_data[fres.pos]),
		"find unit picked an occupied slot")
	`FSA_ASSERT_NOW(a_write_in_eval, mem_we,
		(state_q == fsa_pkg::S_REL_EVAL || state_q == fsa_pkg::S_ALLOC_EVAL),
		"bitmap written outside a check state")
	`FSA_ASSERT_NEXT(a_grant_marked,
		(state_q == fsa_pkg::S_ALLOC_EVAL && !phase_q && fres.found),
		(row_valid_q[grant_q[POS_W-1:BW]] && word_q[grant_q[BW-1:0]]),
		"granted slot not marked occupied")

endmodule

### bench/free_slot_allocator_top_tb.sv
// self-checking testbench of the next-fit slot allocator top level
`timescale 1ns / 1ps

module free_slot_allocator_top_tb;

	import fsa_pkg::*;

	localparam int POOL_SLOTS    = POOL_SLOTS_DEF;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASE_WORDS   = 40;

	typedef enum logic [1:0] {
		STIM_REQ,
		STIM_COUNT,
		STIM_PAUSE
	} stim_kind_t;

	typedef struct {
		stim_kind_t       kind;
		req_item_t        word;
		logic [CFG_W-1:0] count;
		int unsigned      send_idle;
		int unsigned      recv_idle;
	} stim_entry_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	req_item_t        req       = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	rsp_item_t        rsp;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data  = '0;

	// words still to send, results still owed by the block
	stim_entry_t pending_stim[$];
	rsp_item_t   results_due[$];

	// shadow of the allocator state
	bit               slot_taken [POOL_SLOTS];
	int               free_ptr   = 0;
	logic [CFG_W-1:0] slot_count = CFG_RESET;

	int unsigned mismatches    = 0;
	int unsigned gen_send_idle = 34;
	int unsigned gen_recv_idle = 84;
	int unsigned send_idle_pct = 34;
	int unsigned recv_idle_pct = 84;
	logic        req_took      = 1'b0;
	logic        cfg_took      = 1'b0;
	logic        stim_done     = 1'b0;
	bit          draining      = 1'b0;
	int          settle_left   = 0;
	stim_entry_t cur_entry;

	free_slot_allocator_top #(
		.POOL_SLOTS(POOL_SLOTS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin : clock_gen
		forever #1 clk = ~clk;
	end

	initial begin : watchdog
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("%0t mismatch: %s", $realtime, msg);
	endtask

	// first free slot at or after start, wrapping inside n slots; n when none
	function automatic int first_free_from(int start, int n);
		int pos;
		int k;
		pos = start;
		for (k = 0; k < n; k++) begin
			if (!slot_taken[pos])
				return pos;
			pos = (pos + 1 >= n) ? 0 : pos + 1;
		end
		return n;
	endfunction

	// updates the shadow state and gives the result word the block owes
	function automatic rsp_item_t serve_request(req_item_t word);
		rsp_item_t res;
		int        n;
		int        hit;
		int        nxt;
		n = (slot_count == 0) ? 1 : ((slot_count > POOL_SLOTS) ? POOL_SLOTS : int'(slot_count));
		res.granted_slot = '0;
		res.status       = ST_OK;
		if (word.req_type == REQ_ALLOC) begin
			// a pointer left past a shrunken pool restarts the search at zero
			hit = first_free_from((free_ptr < n) ? free_ptr : 0, n);
			if (hit >= n) begin
				res.status = ST_FULL;
			end else begin
				slot_taken[hit]  = 1'b1;
				res.granted_slot = hit[SLOT_W-1:0];
				nxt              = first_free_from(hit, n);
				free_ptr         = (nxt < n) ? nxt : hit;
			end
		end else if (word.slot_index >= n) begin
			res.status = ST_RANGE;
		end else if (!slot_taken[word.slot_index]) begin
			res.status = ST_FREE;
		end else begin
			slot_taken[word.slot_index] = 1'b0;
		end
		return res;
	endfunction

	task automatic push_request(req_t kind, int unsigned idx);
		stim_entry_t e;
		e.kind            = STIM_REQ;
		e.word.req_type   = kind;
		e.word.slot_index = idx[SLOT_W-1:0];
		e.count           = '0;
		e.send_idle       = gen_send_idle;
		e.recv_idle       = gen_recv_idle;
		pending_stim.push_back(e);
	endtask

	// sender holds off until every owed result is back and the block has settled
	task automatic push_pause();
		stim_entry_t e;
		e.kind      = STIM_PAUSE;
		e.word      = '0;
		e.count     = '0;
		e.send_idle = gen_send_idle;
		e.recv_idle = gen_recv_idle;
		pending_stim.push_back(e);
	endtask

	task automatic push_count(int unsigned value);
		stim_entry_t e;
		push_pause();
		e.kind      = STIM_COUNT;
		e.word      = '0;
		e.count     = value[CFG_W-1:0];
		e.send_idle = gen_send_idle;
		e.recv_idle = gen_recv_idle;
		pending_stim.push_back(e);
	endtask

	// ports sampled at the rising edge: checking, prediction, handshake flags
	always @(posedge clk) begin : watch_ports
		rsp_item_t want;
		if (arst_n) begin
			req_took <= req_valid && !req_stall;
			cfg_took <= cfg_valid && cfg_ready;
			if (rsp_valid && !rsp_stall) begin
				if (results_due.size() == 0) begin
					report_mismatch($sformatf("unexpected word: slot %0d status %0d",
						rsp.granted_slot, rsp.status));
				end else begin
					want = results_due.pop_front();
					if (rsp.granted_slot !== want.granted_slot)
						report_mismatch($sformatf("granted_slot %0d, expected %0d",
							rsp.granted_slot, want.granted_slot));
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							rsp.status, want.status));
				end
			end
			if (req_valid && !req_stall)
				results_due.push_back(serve_request(req));
			if (cfg_valid && cfg_ready)
				slot_count = cfg_data;
		end
	end

	// inputs change at the falling edge
	always @(negedge clk) begin : drive_stimulus
		logic hold_req;
		logic hold_cfg;
		hold_req = req_valid && !req_took;
		hold_cfg = cfg_valid && !cfg_took;
		rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		if (!arst_n || hold_req || hold_cfg) begin
			// word on offer stays put until taken
		end else if (draining) begin
			req_valid <= 1'b0;
			cfg_valid <= 1'b0;
			if (results_due.size() == 0) begin
				if (settle_left == 0)
					draining = 1'b0;
				else
					settle_left--;
			end
		end else if (pending_stim.size() == 0) begin
			req_valid <= 1'b0;
			cfg_valid <= 1'b0;
			stim_done <= 1'b1;
		end else if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			cur_entry     = pending_stim.pop_front();
			send_idle_pct = cur_entry.send_idle;
			recv_idle_pct = cur_entry.recv_idle;
			case (cur_entry.kind)
				STIM_REQ: begin
					req_valid <= 1'b1;
					req       <= cur_entry.word;
					cfg_valid <= 1'b0;
				end
				STIM_COUNT: begin
					cfg_valid <= 1'b1;
					cfg_data  <= cur_entry.count;
					req_valid <= 1'b0;
				end
				default: begin
					draining    = 1'b1;
					settle_left = SETTLE_CYCLES;
					req_valid   <= 1'b0;
					cfg_valid   <= 1'b0;
				end
			endcase
		end
	end

	initial begin : run_sequence
		int unsigned counts[12];
		int unsigned top;
		int unsigned pick;
		int          ph;
		int          k;
		counts = '{3, 16, 33, 1024, 64, 7, 2, 100, 1024, 40, 5, 1};

		// directed: releases of free slots at both ends, plain grants
		push_request(REQ_RELEASE, 0);
		push_request(REQ_RELEASE, 1023);
		push_request(REQ_ALLOC, 0);
		push_request(REQ_ALLOC, 1023);
		push_request(REQ_ALLOC, 0);
		push_request(REQ_RELEASE, 1);
		push_request(REQ_RELEASE, 1);
		push_request(REQ_ALLOC, 0);
		// single slot pool: full, last free slot granted, out of range
		push_count(1);
		push_request(REQ_ALLOC, 0);
		push_request(REQ_RELEASE, 0);
		push_request(REQ_ALLOC, 0);
		push_request(REQ_ALLOC, 0);
		push_request(REQ_RELEASE, 512);
		push_request(REQ_RELEASE, 1023);
		// zero count behaves as one slot
		push_count(0);
		push_request(REQ_ALLOC, 0);
		push_request(REQ_RELEASE, 0);
		push_request(REQ_ALLOC, 0);
		// count above the pool saturates, scan steps past taken slots
		push_count(2047);
		push_request(REQ_ALLOC, 0);
		push_request(REQ_RELEASE, 1023);
		// fill a small pool, then shrink it under the pointer
		push_count(8);
		repeat (8) push_request(REQ_ALLOC, 0);
		push_request(REQ_ALLOC, 0);
		push_request(REQ_RELEASE, 6);
		push_request(REQ_ALLOC, 0);
		push_count(4);
		push_request(REQ_RELEASE, 2);
		push_request(REQ_ALLOC, 0);

		// random phases over a spread of pool sizes and idling mixes
		for (ph = 0; ph < 12; ph++) begin
			gen_send_idle = (ph < 4) ? 34 : ((ph < 8) ? 84 : 0);
			gen_recv_idle = (ph < 4) ? 84 : ((ph < 8) ? 34 : 0);
			push_count(counts[ph]);
			top = (counts[ph] > POOL_SLOTS) ? POOL_SLOTS - 1 : counts[ph] - 1;
			for (k = 0; k < PHASE_WORDS; k++) begin
				pick = $urandom_range(99);
				if (k == PHASE_WORDS / 2 && $urandom_range(1) == 0)
					push_pause();
				if (pick < 55)
					push_request(REQ_ALLOC, $urandom_range(1023));
				else if (pick < 90)
					push_request(REQ_RELEASE, $urandom_range(top));
				else
					push_request(REQ_RELEASE, $urandom_range(1023));
			end
		end

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		while (!(stim_done && results_due.size() == 0))
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
